// ===== rtl/xrd_pkg.sv =====
// xrd_pkg: shared types and constants for the xoroshiro128+ draw block
// no dependencies
`timescale 1ns / 1ps

package xrd_pkg;

    localparam logic [63:0] SEED0_RESET = 64'd1;
    localparam logic [63:0] SEED1_RESET = 64'h9E37_79B9_7F4A_7C15;
    localparam int ROT_A = 55;
    localparam int SHIFT_B = 14;
    localparam int ROT_C = 36;
    localparam int FRAC_SHIFT = 12;
    localparam int WORD_BITS = 64;
    localparam int SPAN_BITS = 33;
    localparam int QUEUE_DEPTH = 2;

    localparam logic REG_SEED0 = 1'b0;
    localparam logic REG_SEED1 = 1'b1;

    typedef struct packed {
        logic signed [31:0] range_low;
        logic signed [31:0] range_high;
    } draw_in_t;

    typedef struct packed {
        logic [63:0]        raw_value;
        logic signed [31:0] ranged_value;
        logic [51:0]        unit_fraction;
        logic               range_error;
    } draw_out_t;

    // work item passed from the generator front to the modulo back end
    typedef struct packed {
        logic [63:0]        raw;
        logic [32:0]        span;
        logic signed [31:0] low;
        logic               err;
    } draw_job_t;

endpackage

// ===== rtl/xoroshiro_random_draw.sv =====
// xoroshiro_random_draw: xoroshiro128+ generator with ranged and unit results
// depends on xrd_pkg, xrd_front, xrd_queue, xrd_back
// the one-bit-per-cycle remainder unit finishes each draw before it takes the next;
// the front and a two-entry queue run ahead of it
// reset: synchronous active-low aresetn loads default seeds and empties the queue
`timescale 1ns / 1ps

module xoroshiro_random_draw (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [63:0]         cfg_wr_index,
    input  logic [63:0]         cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  xrd_pkg::draw_in_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output xrd_pkg::draw_out_t  m_data
);

    logic f_valid, f_ready, q_valid, q_ready, idx_ok;
    xrd_pkg::draw_job_t f_data, q_data;

    assign idx_ok = cfg_wr_index[63:1] == '0;

    xrd_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_index(cfg_wr_index[0:0]),
        .cfg_wr_data(cfg_wr_data), .cfg_wr_valid_index(idx_ok),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .job_valid(f_valid), .job_ready(f_ready), .job_data(f_data)
    );

    xrd_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
        .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
    );

    xrd_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .job_valid(q_valid), .job_ready(q_ready), .job_data(q_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

endmodule

// ===== rtl/xrd_front.sv =====
// xrd_front: seed registers, generator state and span computation
// depends on xrd_pkg
`timescale 1ns / 1ps

module xrd_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [0:0]          cfg_wr_index,
    input  logic [63:0]         cfg_wr_data,
    input  logic                cfg_wr_valid_index,
    input  logic                s_valid,
    output logic                s_ready,
    input  xrd_pkg::draw_in_t   s_data,
    output logic                job_valid,
    input  logic                job_ready,
    output xrd_pkg::draw_job_t  job_data
);

    logic [63:0] seed0_reg, seed1_reg, word0_reg, word1_reg;
    logic [63:0] seed0_next, seed1_next;
    logic [63:0] a_w, b_w, w0_step, w1_step;
    logic signed [32:0] low_ext, high_ext, diff_w;
    logic take;

    assign s_ready = job_ready;
    assign job_valid = s_valid;
    assign take = s_valid && job_ready;

    assign a_w = word0_reg;
    assign b_w = word1_reg ^ word0_reg;
    assign w0_step = {a_w[63-xrd_pkg::ROT_A:0], a_w[63:64-xrd_pkg::ROT_A]}
                     ^ b_w ^ (b_w << xrd_pkg::SHIFT_B);
    assign w1_step = {b_w[63-xrd_pkg::ROT_C:0], b_w[63:64-xrd_pkg::ROT_C]};

    assign low_ext = {s_data.range_low[31], s_data.range_low};
    assign high_ext = {s_data.range_high[31], s_data.range_high};
    assign diff_w = high_ext - low_ext;

    always_comb begin
        job_data.raw = word0_reg + word1_reg;
        job_data.low = s_data.range_low;
        job_data.err = !(s_data.range_high > s_data.range_low);
        job_data.span = diff_w;
    end

    always_comb begin
        seed0_next = seed0_reg;
        seed1_next = seed1_reg;
        if (cfg_wr_en && cfg_wr_valid_index) begin
            if (cfg_wr_index == xrd_pkg::REG_SEED0) begin
                seed0_next = cfg_wr_data;
            end else begin
                seed1_next = cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed0_reg <= xrd_pkg::SEED0_RESET;
            seed1_reg <= xrd_pkg::SEED1_RESET;
            word0_reg <= xrd_pkg::SEED0_RESET;
            word1_reg <= xrd_pkg::SEED1_RESET;
        end else begin
            seed0_reg <= seed0_next;
            seed1_reg <= seed1_next;
            if (cfg_wr_en && cfg_wr_valid_index) begin
                word0_reg <= ((seed0_next | seed1_next) == 64'd0) ? 64'd1 : seed0_next;
                word1_reg <= seed1_next;
            end else if (take) begin
                word0_reg <= w0_step;
                word1_reg <= w1_step;
            end
        end
    end

endmodule

// ===== rtl/xrd_queue.sv =====
// xrd_queue: short job queue between generator front and modulo back end
// depends on xrd_pkg
`timescale 1ns / 1ps

module xrd_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  xrd_pkg::draw_job_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output xrd_pkg::draw_job_t  out_data
);

    localparam int DEPTH = xrd_pkg::QUEUE_DEPTH;

    xrd_pkg::draw_job_t mem_reg [DEPTH];
    logic [$clog2(DEPTH)-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [$clog2(DEPTH):0] count_reg;
    logic push, pop;

    assign in_ready = count_reg != DEPTH[$clog2(DEPTH):0];
    assign out_valid = count_reg != '0;
    assign out_data = mem_reg[rd_ptr_reg];
    assign push = in_valid && in_ready;
    assign pop = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop) rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop) count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ===== rtl/xrd_back.sv =====
// xrd_back: bit-serial remainder of raw by span, then result register
// depends on xrd_pkg
`timescale 1ns / 1ps

module xrd_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                job_valid,
    output logic                job_ready,
    input  xrd_pkg::draw_job_t  job_data,
    output logic                m_valid,
    input  logic                m_ready,
    output xrd_pkg::draw_out_t  m_data
);

    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_OUT} state_t;

    localparam int SB = xrd_pkg::SPAN_BITS;

    state_t state_reg;
    logic [6:0] bit_reg;
    logic [63:0] raw_reg, shift_reg;
    logic [SB-1:0] span_reg, rem_reg;
    logic [SB:0] trial_w;
    logic signed [31:0] low_reg;
    logic err_reg;
    xrd_pkg::draw_out_t out_reg;

    assign job_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);
    assign m_data = out_reg;
    assign trial_w = {rem_reg, shift_reg[63]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            bit_reg <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (job_valid) begin
                        raw_reg <= job_data.raw;
                        shift_reg <= job_data.raw;
                        span_reg <= job_data.span;
                        low_reg <= job_data.low;
                        err_reg <= job_data.err;
                        rem_reg <= '0;
                        bit_reg <= 7'd64;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (bit_reg == 7'd0) begin
                        out_reg.raw_value <= raw_reg;
                        out_reg.unit_fraction <= raw_reg[63:xrd_pkg::FRAC_SHIFT];
                        out_reg.range_error <= err_reg;
                        out_reg.ranged_value <= err_reg ? low_reg
                                              : low_reg + rem_reg[31:0];
                        state_reg <= ST_OUT;
                    end else begin
                        shift_reg <= {shift_reg[62:0], 1'b0};
                        if (!err_reg && trial_w >= {1'b0, span_reg}) begin
                            rem_reg <= SB'(trial_w - {1'b0, span_reg});
                        end else begin
                            rem_reg <= trial_w[SB-1:0];
                        end
                        bit_reg <= bit_reg - 7'd1;
                    end
                end
                ST_OUT: begin
                    if (m_ready) state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== bench/tb.sv =====
// tb: self-checking bench for xoroshiro_random_draw, a table of directed draws then
// random draws under several seeds, each result compared with a local predictor
// depends on rtl/xrd_pkg.sv and rtl/xoroshiro_random_draw.sv
`timescale 1ns / 1ps

module tb;

    localparam logic [63:0] IDX_SEED0 = 64'(xrd_pkg::REG_SEED0);
    localparam logic [63:0] IDX_SEED1 = 64'(xrd_pkg::REG_SEED1);
    localparam logic [63:0] IDX_UNUSED = 64'd2;
    localparam logic signed [31:0] MAXI = 32'sh7fffffff;
    localparam logic signed [31:0] MINI = 32'sh80000000;
    localparam int LIMIT = 2000000;
    localparam int RAND_PER_PHASE = 275;
    localparam int DRAIN = 100;
    localparam int PEND_DEPTH = 16;

    typedef struct {
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        bit                 fixed;
        logic signed [31:0] ranged;
        bit                 err;
        bit                 has_raw;
        logic [63:0]        raw;
    } row_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [63:0]         cfg_wr_index = '0;
    logic [63:0]         cfg_wr_data = '0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    xrd_pkg::draw_in_t   s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    xrd_pkg::draw_out_t  m_data;

    logic [63:0] seed0, seed1, gen_w0, gen_w1;
    xrd_pkg::draw_out_t pending_draws [PEND_DEPTH];
    int          pending_wr = 0;
    int          pending_rd = 0;
    int          pending_count = 0;
    int          fails = 0;
    int          draws_sent = 0;
    int          draws_checked = 0;
    int          cycles = 0;
    bit          steady = 1'b0;
    bit          pressure_req = 1'b0;
    bit          pressure_done = 1'b0;
    int          hold_left = 0;
    int          stall_left = 0;

    row_t rows[] = '{
        '{0, 1, 1, 0, 0, 1, 64'h9E3779B97F4A7C16},
        '{5, 5, 1, 5, 1, 0, 0},
        '{10, 3, 1, 10, 1, 0, 0},
        '{MAXI, MINI, 1, MAXI, 1, 0, 0},
        '{MINI, MINI, 1, MINI, 1, 0, 0},
        '{MAXI, MAXI, 1, MAXI, 1, 0, 0},
        '{-1, 0, 1, -1, 0, 0, 0},
        '{MINI, 32'sh80000001, 1, MINI, 0, 0, 0},
        '{32'sh7ffffffe, MAXI, 1, 32'sh7ffffffe, 0, 0, 0},
        '{0, -1, 1, 0, 1, 0, 0},
        '{32'sh55555555, 32'shAAAAAAAA, 1, 32'sh55555555, 1, 0, 0},
        '{32'shAAAAAAAA, 32'sh55555555, 0, 0, 0, 0, 0},
        '{MINI, MAXI, 0, 0, 0, 0, 0},
        '{-100, 100, 0, 0, 0, 0, 0},
        '{0, 2, 0, 0, 0, 0, 0},
        '{MINI, 0, 0, 0, 0, 0, 0},
        '{0, MAXI, 0, 0, 0, 0, 0},
        '{-7, -3, 0, 0, 0, 0, 0},
        '{1000, 1000000, 0, 0, 0, 0, 0}
    };

    xoroshiro_random_draw dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_index(cfg_wr_index), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // expected results waiting for their transfer, oldest first
    function automatic void stash_expected(xrd_pkg::draw_out_t e);
        if (pending_count == PEND_DEPTH) begin
            $error("expected result store overflow");
            fails++;
        end else begin
            pending_draws[pending_wr] = e;
            pending_wr = (pending_wr + 1) % PEND_DEPTH;
            pending_count++;
        end
    endfunction

    function automatic xrd_pkg::draw_out_t take_expected();
        xrd_pkg::draw_out_t e;
        e = pending_draws[pending_rd];
        pending_rd = (pending_rd + 1) % PEND_DEPTH;
        pending_count--;
        return e;
    endfunction

    // generator step: one draw from the current state
    function automatic xrd_pkg::draw_out_t predict_draw(xrd_pkg::draw_in_t d);
        xrd_pkg::draw_out_t r;
        logic [63:0]        a, b, span;
        logic signed [63:0] lo64, hi64;
        a = gen_w0;
        b = gen_w1 ^ gen_w0;
        r.raw_value = gen_w0 + gen_w1;
        gen_w0 = ((a << xrd_pkg::ROT_A) | (a >> (xrd_pkg::WORD_BITS - xrd_pkg::ROT_A)))
                 ^ b ^ (b << xrd_pkg::SHIFT_B);
        gen_w1 = (b << xrd_pkg::ROT_C) | (b >> (xrd_pkg::WORD_BITS - xrd_pkg::ROT_C));
        lo64 = 64'(d.range_low);
        hi64 = 64'(d.range_high);
        r.unit_fraction = r.raw_value[63:xrd_pkg::FRAC_SHIFT];
        if (hi64 > lo64) begin
            span = hi64 - lo64;
            r.ranged_value = 32'((r.raw_value % span) + lo64);
            r.range_error = 1'b0;
        end else begin
            r.ranged_value = d.range_low;
            r.range_error = 1'b1;
        end
        return r;
    endfunction

    // caller stands at a rising edge; returns at the edge of the transfer
    task automatic send_draw(xrd_pkg::draw_in_t d, xrd_pkg::draw_out_t e);
        s_valid <= 1'b1;
        s_data <= d;
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
        stash_expected(e);
        draws_sent++;
    endtask

    task automatic idle_gap();
        int r, n;
        r = $urandom_range(0, 99);
        if (steady || r < 60) return;
        n = (r < 95) ? $urandom_range(1, 3) : $urandom_range(20, 120);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    task automatic write_seed(logic [63:0] idx, logic [63:0] val);
        s_valid <= 1'b0;
        while (pending_count != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == IDX_SEED0) seed0 = val;
        else if (idx == IDX_SEED1) seed1 = val;
        if (idx == IDX_SEED0 || idx == IDX_SEED1) begin
            gen_w0 = (seed0 == 0 && seed1 == 0) ? 64'd1 : seed0;
            gen_w1 = seed1;
        end
    endtask

    function automatic xrd_pkg::draw_in_t random_range();
        xrd_pkg::draw_in_t d;
        logic [63:0]       h;
        int                k;
        k = $urandom_range(0, 9);
        d.range_low = $urandom;
        d.range_high = $urandom;
        if (k >= 3 && k <= 6) begin
            h = 64'(signed'(d.range_low)) + $urandom_range(1, 1000);
            d.range_high = (signed'(h) > 64'(MAXI)) ? MAXI : 32'(h);
        end else if (k == 7) begin
            h = 64'(signed'(d.range_low)) + (64'd1 << $urandom_range(0, 31));
            d.range_high = (signed'(h) > 64'(MAXI)) ? MAXI : 32'(h);
        end else if (k == 8) begin
            d.range_high = d.range_low;
        end else if (k == 9) begin
            d.range_low = $urandom_range(0, 1) ? MINI : -$urandom_range(0, 3);
            d.range_high = $urandom_range(0, 1) ? MAXI : $urandom_range(0, 3);
        end
        return d;
    endfunction

    task automatic compare_draw(xrd_pkg::draw_out_t e, xrd_pkg::draw_out_t a);
        if (a.raw_value !== e.raw_value) begin
            $error("raw_value expected %h got %h", e.raw_value, a.raw_value);
            fails++;
        end
        if (a.ranged_value !== e.ranged_value) begin
            $error("ranged_value expected %0d got %0d", e.ranged_value, a.ranged_value);
            fails++;
        end
        if (a.unit_fraction !== e.unit_fraction) begin
            $error("unit_fraction expected %h got %h", e.unit_fraction, a.unit_fraction);
            fails++;
        end
        if (a.range_error !== e.range_error) begin
            $error("range_error expected %b got %b", e.range_error, a.range_error);
            fails++;
        end
    endtask

    // result side: transfer happens at the next rising edge
    always @(negedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_count == 0) begin
                $error("result transfer with no draw outstanding");
                fails++;
            end else begin
                compare_draw(take_expected(), m_data);
                draws_checked++;
            end
        end
    end

    always @(posedge aclk) begin
        int r;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (pressure_req && !pressure_done) begin
            pressure_done <= 1'b1;
            hold_left <= 600;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (steady) begin
            m_ready <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            m_ready <= (r < 75);
            if (r >= 75) stall_left <= (r < 95) ? $urandom_range(0, 3) : $urandom_range(20, 120);
        end
    end

    initial begin
        xrd_pkg::draw_in_t  d;
        xrd_pkg::draw_out_t e;
        seed0 = xrd_pkg::SEED0_RESET;
        seed1 = xrd_pkg::SEED1_RESET;
        gen_w0 = xrd_pkg::SEED0_RESET;
        gen_w1 = xrd_pkg::SEED1_RESET;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) begin
            d.range_low = rows[i].lo;
            d.range_high = rows[i].hi;
            e = predict_draw(d);
            if (rows[i].fixed) begin
                e.ranged_value = rows[i].ranged;
                e.range_error = rows[i].err;
            end
            if (rows[i].has_raw) begin
                e.raw_value = rows[i].raw;
                e.unit_fraction = rows[i].raw[63:xrd_pkg::FRAC_SHIFT];
            end
            send_draw(d, e);
            idle_gap();
        end

        for (int p = 0; p < 6; p++) begin
            case (p)
                1: begin
                    write_seed(IDX_SEED0, 64'd0);
                    write_seed(IDX_SEED1, 64'd0);
                end
                2: begin
                    write_seed(IDX_SEED0, '1);
                    write_seed(IDX_SEED1, '1);
                end
                3: begin
                    write_seed(IDX_UNUSED, {$urandom, $urandom});
                    write_seed(IDX_SEED0, {$urandom, $urandom});
                    write_seed(IDX_SEED1, {$urandom, $urandom});
                end
                4: write_seed(IDX_SEED1, 64'd0);
                5: begin
                    write_seed(IDX_SEED0, 64'd0);
                    write_seed(IDX_SEED1, {$urandom, $urandom});
                end
                default: ;
            endcase
            steady = (p == 4);
            for (int n = 0; n < RAND_PER_PHASE; n++) begin
                if (p == 2 && n == 20) pressure_req = 1'b1;
                d = random_range();
                send_draw(d, predict_draw(d));
                idle_gap();
            end
        end
        s_valid <= 1'b0;

        while (pending_count != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
        $display("%0d draws over 6 seed settings, %0d results checked, %0d mismatches",
                 draws_sent, draws_checked, fails);
        if (fails == 0 && pending_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
